FILE: rtl/ttl_pkg.sv
// ----------------------------------------------------------------------------
// Touch traffic light package
// Shared types, register indexes, window constants and lamp codes.
// ----------------------------------------------------------------------------
package ttl_pkg;

  localparam int unsigned CoordW   = 12;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  localparam logic [CoordW-1:0] HalfWindow = CoordW'(200);
  localparam logic [CountW-1:0] CountMax   = '1;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegXOffset    = 3'd0,
    RegYOffset    = 3'd1,
    RegStartX     = 3'd2,
    RegStartY     = 3'd3,
    RegPassX      = 3'd4,
    RegPassY      = 3'd5,
    RegHoldTicks  = 3'd6,
    RegPhaseTicks = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeIdle = 2'd0,
    ModeStop = 2'd1,
    ModeGo   = 2'd2,
    ModeWarn = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LampOff    = 2'd0,
    LampGreen  = 2'd1,
    LampYellow = 2'd2,
    LampRed    = 2'd3
  } lamp_e;

  typedef enum logic {
    CmdTick   = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef struct packed {
    coord_t x_offset;
    coord_t y_offset;
    coord_t start_x;
    coord_t start_y;
    coord_t pass_x;
    coord_t pass_y;
    count_t hold_ticks;
    count_t phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic on_start;
    logic on_pass;
  } hit_t;

  function automatic lamp_e lamp_of(mode_e m);
    lamp_e l;
    unique case (m)
      ModeStop: l = LampRed;
      ModeGo:   l = LampGreen;
      ModeWarn: l = LampYellow;
      default:  l = LampOff;
    endcase
    return l;
  endfunction

endpackage

FILE: rtl/ttl_cfg_regs.sv
// ----------------------------------------------------------------------------
// Touch traffic light configuration registers
// Holds calibration, window centers and tick thresholds.
// ----------------------------------------------------------------------------
module ttl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [ttl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ttl_pkg::CfgDataW-1:0]  cfg_data_i,
  output ttl_pkg::cfg_t                 cfg_o
);
  import ttl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_offset    <= CoordW'(1080);
      cfg_q.y_offset    <= CoordW'(1360);
      cfg_q.start_x     <= CoordW'(900);
      cfg_q.start_y     <= CoordW'(900);
      cfg_q.pass_x      <= CoordW'(200);
      cfg_q.pass_y      <= CoordW'(700);
      cfg_q.hold_ticks  <= CountW'(2);
      cfg_q.phase_ticks <= CountW'(5);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegXOffset:    cfg_q.x_offset    <= cfg_data_i;
        RegYOffset:    cfg_q.y_offset    <= cfg_data_i;
        RegStartX:     cfg_q.start_x     <= cfg_data_i;
        RegStartY:     cfg_q.start_y     <= cfg_data_i;
        RegPassX:      cfg_q.pass_x      <= cfg_data_i;
        RegPassY:      cfg_q.pass_y      <= cfg_data_i;
        RegHoldTicks:  cfg_q.hold_ticks  <= cfg_data_i[CountW-1:0];
        RegPhaseTicks: cfg_q.phase_ticks <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/ttl_touch_decode.sv
// ----------------------------------------------------------------------------
// Touch traffic light touch decoder
// Corrects a raw touch point and tests it against both button windows.
// ----------------------------------------------------------------------------
module ttl_touch_decode (
  input  ttl_pkg::coord_t touch_x_i,
  input  ttl_pkg::coord_t touch_y_i,
  input  ttl_pkg::cfg_t   cfg_i,
  output ttl_pkg::hit_t   hit_o
);
  import ttl_pkg::*;

  function automatic coord_t sub_clamp(coord_t a, coord_t b);
    return (a > b) ? coord_t'(a - b) : '0;
  endfunction

  function automatic logic near(coord_t a, coord_t c);
    coord_t d;
    d = (a > c) ? coord_t'(a - c) : coord_t'(c - a);
    return d <= HalfWindow;
  endfunction

  coord_t x;
  coord_t y;

  assign x = sub_clamp(touch_x_i, cfg_i.x_offset);
  assign y = sub_clamp(touch_y_i, cfg_i.y_offset);

  assign hit_o.on_start = near(x, cfg_i.start_x) && near(y, cfg_i.start_y);
  assign hit_o.on_pass  = near(x, cfg_i.pass_x) && near(y, cfg_i.pass_y);

endmodule

FILE: rtl/touch_traffic_light_controller.sv
// ----------------------------------------------------------------------------
// Touch traffic light controller
// Ticks and touch samples drive a four-mode light with start and pass buttons.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// s_axis   in         tvalid, tready, tuser = command, tdata = touch_x, touch_y
// m_axis   out        tvalid, tready, tdata = light_state, lamp
// cfg      in         valid, ready (always high), index, data
//
// Each item passes an input register and a result register; one item per cycle
// is sustained while the result is not stalled. The mode and counter update
// between the two registers sets that rate. A stalled result holds the input
// register, which can still take one item. Reset restores the default
// configuration, idle mode and cleared counters.
// ----------------------------------------------------------------------------
module touch_traffic_light_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [11:0] touch_x, [23:12] touch_y
  input  logic [ttl_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] command
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] light_state, [3:2] lamp, [7:4] zero
  output logic [ttl_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ttl_pkg::CfgDataW-1:0]   cfg_data_i
);
  import ttl_pkg::*;

  cfg_t   cfg;
  hit_t   hit;

  logic   in_valid_q;
  cmd_e   cmd_q;
  coord_t tx_q;
  coord_t ty_q;

  mode_e  mode_q, mode_d;
  count_t hold_q, hold_d;
  count_t phase_q, phase_d;

  logic   out_valid_q;
  mode_e  out_mode_q;
  logic   advance;

  assign cfg_ready_o = 1'b1;

  ttl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ttl_touch_decode u_decode (
    .touch_x_i(tx_q),
    .touch_y_i(ty_q),
    .cfg_i    (cfg),
    .hit_o    (hit)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    logic held;
    held    = hold_q >= cfg.hold_ticks;
    mode_d  = mode_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    if (cmd_q == CmdTick) begin
      hold_d  = (hold_q == CountMax) ? CountMax : count_t'(hold_q + 1'b1);
      phase_d = (phase_q == CountMax) ? CountMax : count_t'(phase_q + 1'b1);
    end else begin
      priority if (hit.on_start) begin
        if (held) begin
          mode_d = (mode_q == ModeIdle) ? ModeStop : ModeIdle;
          hold_d = '0;
        end
      end else if (hit.on_pass && (mode_q == ModeGo || mode_q == ModeStop)) begin
        if (held) begin
          mode_d  = ModeWarn;
          hold_d  = '0;
          phase_d = '0;
        end
      end else begin
        hold_d = '0;
      end
      if (mode_d == ModeIdle) begin
        phase_d = '0;
      end else if (phase_d >= cfg.phase_ticks) begin
        mode_d  = (mode_d == ModeStop) ? ModeGo : ModeStop;
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q <= cmd_e'(s_axis_tuser_i);
      tx_q  <= s_axis_tdata_i[CoordW-1:0];
      ty_q  <= s_axis_tdata_i[2*CoordW-1:CoordW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_mode_q  <= ModeIdle;
      mode_q      <= ModeIdle;
      hold_q      <= '0;
      phase_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        mode_q      <= mode_d;
        hold_q      <= hold_d;
        phase_q     <= phase_d;
        out_mode_q  <= mode_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, lamp_of(out_mode_q), out_mode_q};

  a_tick_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_q == CmdTick |=> $stable(mode_q))
    else $error("mode changed on a tick");

  a_hold_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cmd_q == CmdTick && hold_q == CountMax |=> hold_q == CountMax)
    else $error("hold counter wrapped");

  a_result_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && out_mode_q == mode_q)
    else $error("result does not match the stored mode");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q)
    else $error("input stalled without a pending item");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Touch traffic light controller testbench
// Sends timer ticks and touch samples and checks every light result against a
// cycle-free model of the mode and counter logic. The run uses the default
// calibration, zero and maximum thresholds, clamped offsets and random button
// layouts. Both stream sides stall at random except in the last part.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttl_pkg::*;

  typedef struct packed {
    lamp_e lamp;
    mode_e light_state;
  } light_t;

  localparam cfg_t DefaultCfg = '{
    x_offset: 12'd1080, y_offset: 12'd1360, start_x: 12'd900, start_y: 12'd900,
    pass_x: 12'd200, pass_y: 12'd700, hold_ticks: 8'd2, phase_ticks: 8'd5
  };
  localparam int unsigned StallLimit = 1000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                s_axis_tuser_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cfg_t        ctl_cfg = DefaultCfg;
  mode_e       ctl_mode = ModeIdle;
  count_t      ctl_hold = '0;
  count_t      ctl_phase = '0;
  light_t      light_q[$];
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold = 0;
  bit          idle_on = 1'b1;

  touch_traffic_light_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic lamp_e lamp_for(mode_e m);
    case (m)
      ModeStop: return LampRed;
      ModeGo:   return LampGreen;
      ModeWarn: return LampYellow;
      default:  return LampOff;
    endcase
  endfunction

  function automatic logic in_window(coord_t a, coord_t c);
    coord_t d;
    d = (a > c) ? a - c : c - a;
    return d <= HalfWindow;
  endfunction

  function automatic void predict_light(cmd_e cmd, coord_t raw_x, coord_t raw_y);
    coord_t cx;
    coord_t cy;
    logic   on_start;
    logic   on_pass;
    logic   held;
    light_t r;
    if (cmd == CmdTick) begin
      if (ctl_hold != CountMax) ctl_hold = ctl_hold + 1'b1;
      if (ctl_phase != CountMax) ctl_phase = ctl_phase + 1'b1;
    end else begin
      cx = (raw_x > ctl_cfg.x_offset) ? raw_x - ctl_cfg.x_offset : '0;
      cy = (raw_y > ctl_cfg.y_offset) ? raw_y - ctl_cfg.y_offset : '0;
      on_start = in_window(cx, ctl_cfg.start_x) && in_window(cy, ctl_cfg.start_y);
      on_pass = in_window(cx, ctl_cfg.pass_x) && in_window(cy, ctl_cfg.pass_y);
      held = ctl_hold >= ctl_cfg.hold_ticks;
      if (on_start) begin
        if (held) begin
          ctl_mode = (ctl_mode == ModeIdle) ? ModeStop : ModeIdle;
          ctl_hold = '0;
        end
      end else if (on_pass && (ctl_mode == ModeGo || ctl_mode == ModeStop)) begin
        if (held) begin
          ctl_hold = '0;
          ctl_phase = '0;
          ctl_mode = ModeWarn;
        end
      end else begin
        ctl_hold = '0;
      end
      if (ctl_mode == ModeIdle) begin
        ctl_phase = '0;
      end else if (ctl_phase >= ctl_cfg.phase_ticks) begin
        ctl_mode = (ctl_mode == ModeStop) ? ModeGo : ModeStop;
        ctl_phase = '0;
      end
    end
    r.light_state = ctl_mode;
    r.lamp = lamp_for(ctl_mode);
    light_q.push_back(r);
  endfunction

  // Raw reading that lands around a window center, a little past its edges.
  function automatic coord_t aim(coord_t offset, coord_t center);
    int v;
    v = int'(offset) + int'(center) + int'($urandom_range(0, 420)) - 210;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  task automatic send_item(cmd_e cmd, coord_t x, coord_t y);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_light(cmd, x, y);
  endtask

  task automatic send_tick();
    send_item(CmdTick, coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (light_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegXOffset:    ctl_cfg.x_offset = data;
      RegYOffset:    ctl_cfg.y_offset = data;
      RegStartX:     ctl_cfg.start_x = data;
      RegStartY:     ctl_cfg.start_y = data;
      RegPassX:      ctl_cfg.pass_x = data;
      RegPassY:      ctl_cfg.pass_y = data;
      RegHoldTicks:  ctl_cfg.hold_ticks = data[CountW-1:0];
      RegPhaseTicks: ctl_cfg.phase_ticks = data[CountW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // The unused upper bits of the count registers carry random values.
  task automatic write_all(cfg_t c);
    write_reg(RegXOffset, c.x_offset);
    write_reg(RegYOffset, c.y_offset);
    write_reg(RegStartX, c.start_x);
    write_reg(RegStartY, c.start_y);
    write_reg(RegPassX, c.pass_x);
    write_reg(RegPassY, c.pass_y);
    write_reg(RegHoldTicks, {4'($urandom), c.hold_ticks});
    write_reg(RegPhaseTicks, {4'($urandom), c.phase_ticks});
  endtask

  // Mostly tick runs and presses on either button, with some stray touches.
  task automatic run_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        burst = $urandom_range(1, 6);
        repeat (burst) send_tick();
        sent += burst;
      end else begin
        if (pick < 70) begin
          send_item(CmdSample, aim(ctl_cfg.x_offset, ctl_cfg.start_x),
                    aim(ctl_cfg.y_offset, ctl_cfg.start_y));
        end else if (pick < 88) begin
          send_item(CmdSample, aim(ctl_cfg.x_offset, ctl_cfg.pass_x),
                    aim(ctl_cfg.y_offset, ctl_cfg.pass_y));
        end else begin
          send_item(CmdSample, coord_t'($urandom), coord_t'($urandom));
        end
        sent++;
      end
    end
  endtask

  // Default layout: start button at raw (1980, 2260), pass button at raw (1280, 2060).
  task automatic test_directed();
    send_item(CmdSample, 12'd0, 12'd0);
    send_item(CmdSample, 12'd4095, 12'd4095);
    repeat (2) send_tick();
    send_item(CmdSample, 12'd2180, 12'd2060);
    send_item(CmdSample, 12'd2181, 12'd2060);
    repeat (3) send_tick();
    send_item(CmdSample, 12'd0, 12'd4095);
    repeat (2) send_tick();
    send_item(CmdSample, 12'd1280, 12'd2060);
    repeat (2) send_tick();
    send_item(CmdSample, 12'd1280, 12'd2060);
    repeat (5) send_tick();
    send_item(CmdSample, 12'd0, 12'd0);
    repeat (2) send_tick();
    send_item(CmdSample, 12'd1980, 12'd2260);
    send_item(CmdSample, 12'd1280, 12'd2060);
  endtask

  task automatic test_default_traffic();
    run_traffic(150);
  endtask

  // The pass window overlaps the start window so that start priority is exercised.
  task automatic test_zero_thresholds();
    write_all('{x_offset: '0, y_offset: '0, start_x: 12'd300, start_y: 12'd300,
                pass_x: 12'd300, pass_y: 12'd500, hold_ticks: '0, phase_ticks: '0});
    run_traffic(150);
  endtask

  task automatic test_clamped_offsets();
    write_all('{x_offset: 12'd4095, y_offset: 12'd4095, start_x: '0, start_y: '0,
                pass_x: 12'd150, pass_y: 12'd150, hold_ticks: 8'd1, phase_ticks: 8'd3});
    run_traffic(60);
  endtask

  task automatic test_saturation();
    write_all('{x_offset: '0, y_offset: '0, start_x: 12'd4095, start_y: 12'd4095,
                pass_x: '0, pass_y: '0, hold_ticks: 8'd255, phase_ticks: 8'd255});
    repeat (260) send_tick();
    send_item(CmdSample, 12'd3895, 12'd3895);
    send_item(CmdSample, 12'd3894, 12'd4095);
    send_item(CmdSample, 12'd200, 12'd0);
    send_item(CmdSample, 12'd201, 12'd0);
  endtask

  task automatic test_random_layouts();
    cfg_t c;
    repeat (2) begin
      c.x_offset = coord_t'($urandom_range(0, 2047));
      c.y_offset = coord_t'($urandom_range(0, 2047));
      c.start_x = coord_t'($urandom_range(0, 2047));
      c.start_y = coord_t'($urandom_range(0, 2047));
      c.pass_x = coord_t'($urandom_range(0, 2047));
      c.pass_y = coord_t'($urandom_range(0, 2047));
      c.hold_ticks = count_t'($urandom_range(0, 6));
      c.phase_ticks = count_t'($urandom_range(0, 8));
      write_all(c);
      run_traffic(130);
    end
  endtask

  task automatic test_pause_resume();
    run_traffic(40);
    wait_drained();
    run_traffic(40);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    write_all(DefaultCfg);
    run_traffic(120);
  endtask

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      sink_hold <= $urandom_range(0, 9);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    light_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (light_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual %0h", $time,
                 m_axis_tdata_o);
      end else begin
        want = light_q.pop_front();
        if (m_axis_tdata_o[1:0] !== want.light_state) begin
          err_count++;
          $display("%0t: light_state mismatch, expected %0d, actual %0d", $time,
                   want.light_state, m_axis_tdata_o[1:0]);
        end
        if (m_axis_tdata_o[3:2] !== want.lamp) begin
          err_count++;
          $display("%0t: lamp mismatch, expected %0d, actual %0d", $time,
                   want.lamp, m_axis_tdata_o[3:2]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_default_traffic();
    test_zero_thresholds();
    test_clamped_offsets();
    test_saturation();
    test_random_layouts();
    test_pause_resume();
    test_full_rate();
    wait_drained();
    if (err_count == 0 && light_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: touch_traffic_light_controller.f
rtl/ttl_pkg.sv
rtl/ttl_cfg_regs.sv
rtl/ttl_touch_decode.sv
rtl/touch_traffic_light_controller.sv
tb/tb_top.sv
